@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the depthwise convolution tile.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DWC_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("%m: check failed");

`define DWC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define DWC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define DWC_ASSERT(lbl, clk, rstn, expr)
`define DWC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define DWC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/dwc_pkg.sv @@
// Constants, codes and types shared by the depthwise convolution tile.
`default_nettype none

package dwc_pkg;

  localparam int TILE_ROWS   = 8;
  localparam int TILE_COLS   = 16;
  localparam int LANES       = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int K           = 3;
  localparam int PAD         = 1;

  localparam int WIN_ROWS = TILE_ROWS + K - 1;
  localparam int WIN_COLS = TILE_COLS + K - 1;
  localparam int NUM_TAPS = K * K;
  localparam int LINE_LEN = (K - 1) * WIN_COLS + K - 1;

  localparam int IMG_W     = 13;
  localparam int POS_W     = 12;
  localparam int WIDX_W    = 4;
  localparam int FUNC_W    = 1;
  localparam int CFG_IDX_W = 4;

  localparam int RR_W  = $clog2(WIN_ROWS);
  localparam int CC_W  = $clog2(WIN_COLS);
  localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int COL_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int TAP_W = $clog2(NUM_TAPS);

  localparam int PROD_W   = 2 * SAMPLE_BITS;
  localparam int ROWSUM_W = PROD_W + 2;
  localparam int RESULT_W = 36;

  localparam int IN_FIELDS_W  = WIDX_W + 2 * POS_W + LANES * SAMPLE_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ROW_W + COL_W + LANES * RESULT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WEIGHT = 1'b0,
    FUNC_PIXEL  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS = 4'd0,
    REG_IMAGE_COLS = 4'd1
  } cfg_reg_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      product_t;
  typedef logic signed [ROWSUM_W-1:0]    rowsum_t;
  typedef logic signed [RESULT_W-1:0]    result_t;

  typedef sample_t [LANES-1:0]    lane_samples_t;
  typedef sample_t [NUM_TAPS-1:0] taps_t;
  typedef taps_t [LANES-1:0]      window_t;
  typedef rowsum_t [K-1:0]        lane_rows_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } stage_ctrl_t;

  typedef struct packed {
    logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
    lane_samples_t                     values;
    logic [POS_W-1:0]                  tile_col;
    logic [POS_W-1:0]                  tile_row;
    logic [WIDX_W-1:0]                 weight_index;
  } in_data_t;

  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
    result_t [LANES-1:0]                 results;
    logic [COL_W-1:0]                    col;
    logic [ROW_W-1:0]                    row;
  } out_data_t;

endpackage

`default_nettype wire

@@ hdl/depthwise_conv3x3_tile.sv @@
// Top level of the four-lane depthwise 3x3 convolution tile.
`default_nettype none
`include "assert_macros.svh"

// The block takes one item per clock cycle unless s_axis_tready is held low by
// back-pressure or a waiting window, and presents a result on the output once the pixel
// that completes a 3x3 window has passed the window register, multipliers, row adders
// and output register, with four lanes of nine multipliers working in parallel. Weight
// items load one tap for all four lanes and are held off while a completed window waits
// to enter the multipliers, so a weight load following a window pixel may be delayed.
// Pixel items stream the 10 by 18 window in raster order; the last pixel of a window
// returns the position to the start. Taps read before they are loaded give undefined results.
module depthwise_conv3x3_tile (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // weight_index, tile_row, tile_col, value_0, value_1, value_2, value_3, zero fill
  input  logic [dwc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // func
  input  logic [dwc_pkg::FUNC_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_row, out_col, result_0, result_1, result_2, result_3, zero fill
  output logic [dwc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // last_of_tile
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dwc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dwc_pkg::IMG_W-1:0]            cfg_data_i
);
  import dwc_pkg::*;

  in_data_t    in_data;
  out_data_t   out_view;
  logic        out_at_corner;
  logic        is_pixel;
  logic        pix_acc, wgt_acc;
  logic        emit;
  logic [IMG_W-1:0] image_rows_q, image_cols_q;
  logic        win_valid_q, prod_valid_q, sum_valid_q;
  logic        win_en, prod_en, sum_en, out_en;
  window_t     taps, weights;
  meta_t       win_meta, prod_meta_q, sum_meta_q;
  stage_ctrl_t lane_ctrl;
  lane_rows_t [LANES-1:0] lane_rows;

  assign in_data  = in_data_t'(s_axis_tdata);
  assign is_pixel = (func_e'(s_axis_tuser) == FUNC_PIXEL);

  assign sum_en  = !sum_valid_q || out_en;
  assign prod_en = !prod_valid_q || sum_en;
  assign win_en  = !win_valid_q || prod_en;

  // A tap load must not overtake a window still waiting for its products.
  assign s_axis_tready = is_pixel ? win_en : !win_valid_q;
  assign pix_acc = s_axis_tvalid && s_axis_tready && is_pixel;
  assign wgt_acc = s_axis_tvalid && s_axis_tready && !is_pixel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q <= IMG_W'(1);
      image_cols_q <= IMG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_ROWS: image_rows_q <= cfg_data_i;
        REG_IMAGE_COLS: image_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dwc_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_load_i     (pix_acc),
    .wgt_load_i     (wgt_acc),
    .weight_index_i (in_data.weight_index),
    .tile_row_i     (in_data.tile_row),
    .tile_col_i     (in_data.tile_col),
    .values_i       (in_data.values),
    .image_rows_i   (image_rows_q),
    .image_cols_i   (image_cols_q),
    .emit_o         (emit),
    .taps_o         (taps),
    .weights_o      (weights),
    .meta_o         (win_meta)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q  <= 1'b0;
      prod_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
    end else begin
      if (win_en) begin
        win_valid_q <= pix_acc && emit;
      end
      if (prod_en) begin
        prod_valid_q <= win_valid_q;
      end
      if (sum_en) begin
        sum_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en) begin
      prod_meta_q <= win_meta;
    end
    if (sum_en) begin
      sum_meta_q <= prod_meta_q;
    end
  end

  assign lane_ctrl.prod_en = prod_en;
  assign lane_ctrl.sum_en  = sum_en;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    dwc_lane u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .taps_i    (taps[l]),
      .weights_i (weights[l]),
      .rowsum_o  (lane_rows[l])
    );
  end

  dwc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (sum_valid_q),
    .meta_i        (sum_meta_q),
    .rowsum_i      (lane_rows),
    .ready_o       (out_en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign out_view      = out_data_t'(m_axis_tdata);
  assign out_at_corner = (out_view.row == ROW_W'(TILE_ROWS - 1))
                      && (out_view.col == COL_W'(TILE_COLS - 1));

  `DWC_ASSERT_IMPL(a_wgt_after_drain, clk_i, rst_ni, wgt_acc, !win_valid_q)
  `DWC_ASSERT_NEXT(a_win_follows_emit, clk_i, rst_ni, pix_acc, win_valid_q == $past(emit))
  `DWC_ASSERT_IMPL(a_last_at_corner, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, out_at_corner)

endmodule

`default_nettype wire

@@ hdl/dwc_window.sv @@
// Window former: raster position, zero padding, two-row shift line and tap weights.
`default_nettype none

module dwc_window (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pix_load_i,
  input  logic                   wgt_load_i,
  input  logic [dwc_pkg::WIDX_W-1:0] weight_index_i,
  input  logic [dwc_pkg::POS_W-1:0]  tile_row_i,
  input  logic [dwc_pkg::POS_W-1:0]  tile_col_i,
  input  dwc_pkg::lane_samples_t values_i,
  input  logic [dwc_pkg::IMG_W-1:0]  image_rows_i,
  input  logic [dwc_pkg::IMG_W-1:0]  image_cols_i,
  output logic                   emit_o,
  output dwc_pkg::window_t       taps_o,
  output dwc_pkg::window_t       weights_o,
  output dwc_pkg::meta_t         meta_o
);
  import dwc_pkg::*;

  logic [RR_W-1:0] rr_q, rr_d;
  logic [CC_W-1:0] cc_q, cc_d;
  logic [IMG_W-1:0] trow, tcol;
  logic            in_image;
  lane_samples_t   cur;
  lane_samples_t   line_q [LINE_LEN];
  lane_samples_t   tap_src [NUM_TAPS];
  window_t         win;
  window_t         taps_q;
  window_t         wgt_q;
  meta_t           meta, meta_q;

  always_comb begin
    cc_d = cc_q + CC_W'(1);
    rr_d = rr_q;
    if (cc_q == CC_W'(WIN_COLS - 1)) begin
      cc_d = '0;
      rr_d = (rr_q == RR_W'(WIN_ROWS - 1)) ? '0 : rr_q + RR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q <= '0;
      cc_q <= '0;
    end else if (pix_load_i) begin
      rr_q <= rr_d;
      cc_q <= cc_d;
    end
  end

  assign trow = IMG_W'(tile_row_i) + IMG_W'(rr_q);
  assign tcol = IMG_W'(tile_col_i) + IMG_W'(cc_q);
  assign in_image = (trow >= IMG_W'(PAD))
                 && ((IMG_W+1)'(trow) < (IMG_W+1)'(image_rows_i) + (IMG_W+1)'(PAD))
                 && (tcol >= IMG_W'(PAD))
                 && ((IMG_W+1)'(tcol) < (IMG_W+1)'(image_cols_i) + (IMG_W+1)'(PAD));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cur[l] = in_image ? values_i[l] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_load_i) begin
      line_q[0] <= cur;
      for (int i = 1; i < LINE_LEN; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
    localparam int DLY = (K - 1 - t / K) * WIN_COLS + (K - 1 - t % K);
    if (DLY == 0) begin : g_cur
      assign tap_src[t] = cur;
    end else begin : g_line
      assign tap_src[t] = line_q[DLY-1];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        win[l][t] = tap_src[t][l];
      end
    end
  end

  assign emit_o = (rr_q >= RR_W'(K - 1)) && (cc_q >= CC_W'(K - 1));

  always_comb begin
    meta.row  = ROW_W'(rr_q - RR_W'(K - 1));
    meta.col  = COL_W'(cc_q - CC_W'(K - 1));
    meta.last = (rr_q == RR_W'(WIN_ROWS - 1)) && (cc_q == CC_W'(WIN_COLS - 1));
  end

  always_ff @(posedge clk_i) begin
    if (pix_load_i) begin
      taps_q <= win;
      meta_q <= meta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wgt_load_i && (weight_index_i < WIDX_W'(NUM_TAPS))) begin
      for (int l = 0; l < LANES; l++) begin
        wgt_q[l][weight_index_i[TAP_W-1:0]] <= values_i[l];
      end
    end
  end

  assign taps_o    = taps_q;
  assign weights_o = wgt_q;
  assign meta_o    = meta_q;

endmodule

`default_nettype wire

@@ hdl/dwc_lane.sv @@
// One channel lane: nine tap products, then one partial sum per kernel row.
`default_nettype none

module dwc_lane (
  input  logic                 clk_i,
  input  dwc_pkg::stage_ctrl_t ctrl_i,
  input  dwc_pkg::taps_t       taps_i,
  input  dwc_pkg::taps_t       weights_i,
  output dwc_pkg::lane_rows_t  rowsum_o
);
  import dwc_pkg::*;

  product_t   prod_q [NUM_TAPS];
  lane_rows_t rows_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        prod_q[t] <= PROD_W'($signed(taps_i[t]) * $signed(weights_i[t]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      for (int r = 0; r < K; r++) begin
        rows_q[r] <= ROWSUM_W'(prod_q[r*K]) + ROWSUM_W'(prod_q[r*K+1])
                   + ROWSUM_W'(prod_q[r*K+2]);
      end
    end
  end

  assign rowsum_o = rows_q;

endmodule

`default_nettype wire

@@ hdl/dwc_merge.sv @@
// Output stage: adds the row sums of every lane and holds the packed result transfer.
`default_nettype none

module dwc_merge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  dwc_pkg::meta_t                        meta_i,
  input  dwc_pkg::lane_rows_t [dwc_pkg::LANES-1:0] rowsum_i,
  output logic                                  ready_o,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_row, out_col, result_0, result_1, result_2, result_3, zero fill
  output logic [dwc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // last_of_tile
  output logic                                  m_axis_tlast
);
  import dwc_pkg::*;

  logic      valid_q;
  out_data_t data_d, data_q;
  logic      last_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_comb begin
    data_d     = '0;
    data_d.row = meta_i.row;
    data_d.col = meta_i.col;
    for (int l = 0; l < LANES; l++) begin
      data_d.results[l] = RESULT_W'(rowsum_i[l][0]) + RESULT_W'(rowsum_i[l][1])
                        + RESULT_W'(rowsum_i[l][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      last_q <= meta_i.last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire
